// File: design/gmps_pkg.sv
// Package with the shared constants, types and helper functions of the grid path sum unit.
`timescale 1ns / 1ps
package gmps_pkg;

  localparam int MAX_SIDE    = 128;
  localparam int WEIGHT_BITS = 16;
  localparam int CELL_COUNT  = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W       = $clog2(CELL_COUNT);
  localparam int CNT_W       = $clog2(CELL_COUNT + 1);
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W      = 8;
  localparam int IN_W        = 16;
  localparam int DIST_W      = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Start request from the loader to the search engine.
  typedef struct packed {
    logic                   start;
    logic [SIDE_W-1:0]      side;
    logic [IDX_W-1:0]       last;
    logic [WEIGHT_BITS-1:0] w0;
  } gmps_ctrl_t;

  // Completion status from the search engine.
  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] path_sum;
  } gmps_stat_t;

  // Distance plus weight, held at the top of the range on overflow.
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [WEIGHT_BITS-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, DIST_W'(b)};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  // Side in use: zero counts as one, large values stop at the maximum.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    if (s == '0) begin
      return SIDE_W'(1);
    end
    if (int'(s) > MAX_SIDE) begin
      return SIDE_W'(MAX_SIDE);
    end
    return s;
  endfunction

endpackage

// File: design/gmps_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module gmps_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/gmps_engine.sv
// Search engine: repeated relaxation sweeps over the grid with one shared add and compare unit.
`timescale 1ns / 1ps
module gmps_engine
  import gmps_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gmps_ctrl_t             ctrl_i,
  output logic [IDX_W-1:0]       w_raddr_o,
  input  logic [WEIGHT_BITS-1:0] w_rdata_i,
  output gmps_stat_t             stat_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CAPT  = 3'd4;

  localparam logic [2:0] PH_UP    = 3'd0;
  localparam logic [2:0] PH_DOWN  = 3'd1;
  localparam logic [2:0] PH_LEFT  = 3'd2;
  localparam logic [2:0] PH_RIGHT = 3'd3;
  localparam logic [2:0] PH_SELF  = 3'd4;
  localparam logic [2:0] PH_WRITE = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [2:0]             phase_q, phase_d;
  logic [IDX_W-1:0]       c_q, c_d;
  logic [COORD_W-1:0]     x_q, x_d, y_q, y_d;
  logic                   fwd_q, fwd_d;
  logic                   changed_q, changed_d;
  logic [SIDE_W-1:0]      side_q, side_d;
  logic [IDX_W-1:0]       last_q, last_d;
  logic [WEIGHT_BITS-1:0] w0_q, w0_d;
  logic [DIST_W-1:0]      min_q, min_d;
  logic [WEIGHT_BITS-1:0] wt_q, wt_d;

  logic                   d_we;
  logic [IDX_W-1:0]       d_waddr, d_raddr;
  logic [DIST_W-1:0]      d_wdata, d_rdata;
  logic [COORD_W-1:0]     xmax;
  logic [3:0]             nb_ok;
  logic                   data_ok;
  logic [DIST_W-1:0]      cand;
  logic                   better;
  logic                   at_end;

  gmps_ram #(
    .DEPTH(CELL_COUNT),
    .WIDTH(DIST_W)
  ) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  // Neighbour presence for the current cell: up, down, left, right.
  assign xmax  = COORD_W'(side_q - SIDE_W'(1));
  assign nb_ok = {x_q != xmax, x_q != '0, y_q != xmax, y_q != '0};

  // Shared candidate: best neighbour plus own weight against own distance.
  assign cand    = sat_add(min_q, wt_q);
  assign better  = cand < d_rdata;
  assign at_end  = fwd_q ? (c_q == last_q) : (c_q == '0);
  assign data_ok = (phase_q >= PH_DOWN) && (phase_q <= PH_SELF) &&
                   nb_ok[2'(phase_q - PH_DOWN)];

  assign w_raddr_o = c_q;

  // Sequencer and datapath.
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    c_d       = c_q;
    x_d       = x_q;
    y_d       = y_q;
    fwd_d     = fwd_q;
    changed_d = changed_q;
    side_d    = side_q;
    last_d    = last_q;
    w0_d      = w0_q;
    min_d     = min_q;
    wt_d      = wt_q;
    d_we      = 1'b0;
    d_waddr   = c_q;
    d_wdata   = DIST_MAX;
    d_raddr   = c_q;
    stat_o.done     = 1'b0;
    stat_o.path_sum = d_rdata;

    case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          side_d  = ctrl_i.side;
          last_d  = ctrl_i.last;
          w0_d    = ctrl_i.w0;
          c_d     = '0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        // Clearing pass: the start cell holds its own weight, the rest the maximum.
        d_we    = 1'b1;
        d_wdata = (c_q == '0) ? DIST_W'(w0_q) : DIST_MAX;
        if (c_q == last_q) begin
          c_d       = '0;
          x_d       = '0;
          y_d       = '0;
          fwd_d     = 1'b1;
          changed_d = 1'b0;
          phase_d   = PH_UP;
          state_d   = ST_SWEEP;
        end else begin
          c_d = c_q + IDX_W'(1);
        end
      end
      ST_SWEEP: begin
        case (phase_q)
          PH_UP:    d_raddr = c_q - IDX_W'(side_q);
          PH_DOWN:  d_raddr = c_q + IDX_W'(side_q);
          PH_LEFT:  d_raddr = c_q - IDX_W'(1);
          PH_RIGHT: d_raddr = c_q + IDX_W'(1);
          default:  d_raddr = c_q;
        endcase
        if (phase_q == PH_UP) begin
          min_d = DIST_MAX;
        end else if (data_ok && d_rdata < min_q) begin
          min_d = d_rdata;
        end
        if (phase_q == PH_DOWN) begin
          wt_d = w_rdata_i;
        end
        if (phase_q == PH_WRITE) begin
          d_we    = better;
          d_wdata = cand;
          phase_d = PH_UP;
          if (at_end) begin
            if (changed_q || better) begin
              fwd_d     = !fwd_q;
              changed_d = 1'b0;
            end else begin
              state_d = ST_READ;
            end
          end else begin
            changed_d = changed_q || better;
            if (fwd_q) begin
              c_d = c_q + IDX_W'(1);
              if (x_q == xmax) begin
                x_d = '0;
                y_d = y_q + COORD_W'(1);
              end else begin
                x_d = x_q + COORD_W'(1);
              end
            end else begin
              c_d = c_q - IDX_W'(1);
              if (x_q == '0) begin
                x_d = xmax;
                y_d = y_q - COORD_W'(1);
              end else begin
                x_d = x_q - COORD_W'(1);
              end
            end
          end
        end else begin
          phase_d = phase_q + 3'd1;
        end
      end
      ST_READ: begin
        d_raddr = last_q;
        state_d = ST_CAPT;
      end
      ST_CAPT: begin
        state_d = ST_IDLE;
        stat_o.done = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_UP;
      fwd_q     <= 1'b1;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      fwd_q     <= fwd_d;
      changed_q <= changed_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    x_q    <= x_d;
    y_q    <= y_d;
    side_q <= side_d;
    last_q <= last_d;
    w0_q   <= w0_d;
    min_q  <= min_d;
    wt_q   <= wt_d;
  end

endmodule

// File: design/grid_min_path_sum_unit.sv
// Top level of the grid path sum unit: loading, configuration and result register.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata[15:0] cell_weight
//  m_axis    | out       | tdata[31:0] path_sum, tuser[0] found
//  cfg       | in        | cfg_data_i[7:0] grid_side
//
// Cells load at one item per cycle into the weight memory.
// After the last cell the search clears side*side distance entries, then runs
// sweeps with up, down, left, right, self and write phases per cell, set by the
// single read port of the distance memory, until a sweep changes nothing.
// No item is taken during the search; the last cell of a grid waits while a
// result is still held. Reset sets grid_side to 80 and clears all control state.
`timescale 1ns / 1ps
module grid_min_path_sum_unit
  import gmps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // [15:0] cell_weight
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DIST_W-1:0] m_axis_tdata,   // [31:0] path_sum
  output logic              m_axis_tuser,   // [0] found
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIDE_W-1:0] cfg_data_i
);

  logic [SIDE_W-1:0]      side_q;
  logic [CNT_W-1:0]       loaded_q;
  logic                   search_q;
  logic                   out_valid_q;
  logic [DIST_W-1:0]      out_sum_q;
  logic [WEIGHT_BITS-1:0] w0_q;
  logic [SIDE_W-1:0]      side_use;
  logic [CNT_W-1:0]       cells;
  logic                   last_cell;
  logic                   in_acc;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [IDX_W-1:0]       w_raddr;
  logic [WEIGHT_BITS-1:0] w_rdata;
  gmps_ctrl_t             ctrl;
  gmps_stat_t             stat;

  assign side_use  = clamp_side(side_q);
  assign cells     = CNT_W'(side_use) * CNT_W'(side_use);
  assign last_cell = (loaded_q + CNT_W'(1)) == cells;
  assign w_in      = WEIGHT_BITS'(s_axis_tdata);

  assign s_axis_tready = !search_q && !(out_valid_q && last_cell);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign ctrl.start = in_acc && last_cell;
  assign ctrl.side  = side_use;
  assign ctrl.last  = IDX_W'(cells - CNT_W'(1));
  assign ctrl.w0    = (loaded_q == '0) ? w_in : w0_q;

  gmps_ram #(
    .DEPTH(CELL_COUNT),
    .WIDTH(WEIGHT_BITS)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(loaded_q[IDX_W-1:0]),
    .wdata_i(w_in),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  gmps_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .w_raddr_o(w_raddr),
    .w_rdata_i(w_rdata),
    .stat_o   (stat)
  );

  // Load counter, side register and search flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= SIDE_W'(80);
      loaded_q <= '0;
      search_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        side_q   <= cfg_data_i;
        loaded_q <= '0;
      end else if (in_acc) begin
        loaded_q <= last_cell ? '0 : loaded_q + CNT_W'(1);
      end
      if (ctrl.start) begin
        search_q <= 1'b1;
      end else if (stat.done) begin
        search_q <= 1'b0;
      end
    end
  end

  // Start cell weight.
  always_ff @(posedge clk_i) begin
    if (in_acc && loaded_q == '0) begin
      w0_q <= w_in;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_sum_q <= stat.path_sum;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sum_q;
  assign m_axis_tuser  = 1'b1;

endmodule

// File: design/gmps_checker.sv
// Port-level checker for the grid path sum unit, bound to the top level.
`timescale 1ns / 1ps
module gmps_checker
  import gmps_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DIST_W-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A full grid is always connected, so every result reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser)
    else $error("result without found flag");

  // No result is offered straight out of reset.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result present after reset");

  // While a result waits unaccepted, no new search can finish, so the value holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind grid_min_path_sum_unit gmps_checker u_gmps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
